// File: rtl/wbps_pkg.sv
// Shared constants and types for the wildcard byte pattern search block.
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES_DEF = 16;
    localparam int OFFSET_BITS_DEF       = 32;

    localparam int REG_PATTERN_BYTES = 16;
    localparam int PATTERN_W         = 8 * REG_PATTERN_BYTES;
    localparam int CARE_W            = 2 * REG_PATTERN_BYTES;
    localparam int LEN_W             = 5;
    localparam int OUT_OFFSET_W      = 32;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 2'd3;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic [CARE_W-1:0]    care;
        logic [LEN_W-1:0]     len;
    } t_sig_cfg;

endpackage

// File: rtl/wbps_if.sv
// Item channel interfaces for the input byte stream and the search result.
interface wbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface wbps_out_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [31:0] match_offset;

    modport source (output valid, match_found, match_offset, input ready);
    modport sink   (input valid, match_found, match_offset, output ready);
endinterface

// File: rtl/wbps_match.sv
// Parallel masked compare of the byte window against the signature.
module wbps_match #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
    input  wbps_pkg::t_byte   i_window [MAX_PATTERN_BYTES],
    input  wbps_pkg::t_sig_cfg i_cfg,
    output logic              o_match
);

    localparam int LANES = (MAX_PATTERN_BYTES < wbps_pkg::REG_PATTERN_BYTES) ?
                           MAX_PATTERN_BYTES : wbps_pkg::REG_PATTERN_BYTES;
    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    logic [LANES-1:0] lane_hit;
    logic             len_ok;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        logic [wbps_pkg::LEN_W-1:0] d;
        logic [7:0]                 care;
        logic [7:0]                 sig;
        wbps_pkg::t_byte            win;

        assign d    = i_cfg.len - wbps_pkg::LEN_W'(g) - wbps_pkg::LEN_W'(1);
        assign win  = i_window[d[IDX_W-1:0]];
        assign sig  = i_cfg.pattern[8*g +: 8];
        assign care = {{4{i_cfg.care[2*g]}}, {4{i_cfg.care[2*g+1]}}};
        assign lane_hit[g] = (wbps_pkg::LEN_W'(g) >= i_cfg.len) ||
                             (((win ^ sig) & care) == 8'd0);
    end

    assign len_ok = (i_cfg.len != '0) &&
                    ({1'b0, i_cfg.len} <= 6'(MAX_PATTERN_BYTES)) &&
                    ({1'b0, i_cfg.len} <= 6'(wbps_pkg::REG_PATTERN_BYTES));

    assign o_match = len_ok && (&lane_hit);

endmodule

// File: rtl/wildcard_byte_pattern_search_top.sv
// Top level of the wildcard byte pattern search block.
//
// i_in carries one buffer byte per item with first_byte and last_byte marks.
// o_out carries at most one result per buffer: the start offset of the first
// signature match, or not found on the last byte. The config write port sets
// the pattern, the nibble care mask and the length; the user must write it
// only while no item is in flight, as the block does not enforce this. An
// accepted item sits in an input register; the window shift, the masked
// compare over all signature bytes and the offset subtract run from it into
// the output register. Throughput is one item per cycle, set by the single
// compare stage, while the output register is empty or its result is taken.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more item; i_in.ready drops only when both
// are full. Reset clears the config, both valid flags, the position, the fill
// count and done flag; the window needs no clearing, the fill count guards it.
module wildcard_byte_pattern_search_top #(
    parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS       = wbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wbps_in_if.sink                            i_in,
    wbps_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

    wbps_pkg::t_sig_cfg r_cfg;

    logic       r_in_valid;
    logic [7:0] r_data;
    logic       r_first;
    logic       r_last;

    wbps_pkg::t_byte r_window [MAX_PATTERN_BYTES];
    wbps_pkg::t_byte n_window [MAX_PATTERN_BYTES];
    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      n_fill;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] n_pos;
    logic                   r_done;
    logic                   n_done;

    logic                                r_out_valid;
    logic                                r_found;
    logic [wbps_pkg::OUT_OFFSET_W-1:0]   r_offset;

    logic                   process;
    logic                   eff_done;
    logic [FILL_W-1:0]      eff_fill;
    logic [OFFSET_BITS-1:0] eff_pos;
    logic                   match;
    logic                   hit;
    logic                   produce;
    logic [OFFSET_BITS-1:0] start_pos;

    assign process     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || process;

    assign eff_done = r_first ? 1'b0 : r_done;
    assign eff_fill = r_first ? '0 : r_fill;
    assign eff_pos  = r_first ? '0 : r_pos;

    always_comb begin
        n_window[0] = r_data;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    wbps_match #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_match (
        .i_window (n_window),
        .i_cfg    (r_cfg),
        .o_match  (match)
    );

    assign n_fill = (eff_fill == FILL_W'(MAX_PATTERN_BYTES)) ? eff_fill
                                                             : eff_fill + FILL_W'(1);
    assign n_pos  = eff_pos + OFFSET_BITS'(1);
    assign hit    = !eff_done && match && (7'(n_fill) >= 7'(r_cfg.len));
    assign produce = !eff_done && (hit || r_last);
    assign n_done = eff_done || produce;
    assign start_pos = eff_pos - OFFSET_BITS'(r_cfg.len) + OFFSET_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_in_valid  <= 1'b0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wbps_pkg::CFG_PATTERN_LOW:  r_cfg.pattern[63:0]   <= i_cfg_data;
                    wbps_pkg::CFG_PATTERN_HIGH: r_cfg.pattern[127:64] <= i_cfg_data;
                    wbps_pkg::CFG_CARE_MASK:
                        r_cfg.care <= i_cfg_data[wbps_pkg::CARE_W-1:0];
                    wbps_pkg::CFG_PATTERN_LEN:
                        r_cfg.len  <= i_cfg_data[wbps_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end

            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end

            if (process) begin
                r_done <= n_done;
                if (!eff_done) begin
                    r_fill <= n_fill;
                    r_pos  <= n_pos;
                end else begin
                    r_fill <= eff_fill;
                    r_pos  <= eff_pos;
                end
            end

            if (process && produce) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data  <= i_in.data_byte;
            r_first <= i_in.first_byte;
            r_last  <= i_in.last_byte;
        end
        if (process && !eff_done) begin
            r_window <= n_window;
        end
        if (process && produce) begin
            r_found  <= hit;
            r_offset <= hit ? wbps_pkg::OUT_OFFSET_W'(start_pos) : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.match_found  = r_found;
    assign o_out.match_offset = r_offset;

    a_done_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && r_done && !r_first) |-> !produce)
        else $error("result produced after the buffer was already reported");

    a_hit_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && hit) |-> (r_cfg.len != '0))
        else $error("match with zero pattern length");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_PATTERN_BYTES))
        else $error("window fill count above window depth");

    a_report_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (process && produce) |=> (r_done && r_out_valid))
        else $error("report did not set done or load the output register");

endmodule
